>>> rtl/fdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdt_pkg
// Shared widths, register codes, reset values and types of the fan duty block.
// ----------------------------------------------------------------------------
package fdt_pkg;

  // averaging ring
  localparam int AVG_DEPTH = 5;
  localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W     = $clog2(AVG_DEPTH + 1);

  // field widths
  localparam int SAMPLE_W = 12;
  localparam int DUTY_W   = 8;
  localparam int HYST_W   = 9;
  localparam int FAIL_W   = 4;
  localparam int SUM_W    = SAMPLE_W + $clog2(AVG_DEPTH) + 1;

  // curve arithmetic
  localparam int CALC_W     = SAMPLE_W + 2;
  localparam int DD_W       = DUTY_W + 2;
  localparam int PROD_W     = CALC_W + DD_W;
  localparam int DIVIDEND_W = PROD_W;
  localparam int DIVISOR_W  = SAMPLE_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // reading validity window, exclusive
  localparam logic signed [SAMPLE_W-1:0] LOW_BOUND  = -12'sd800;
  localparam logic signed [SAMPLE_W-1:0] HIGH_BOUND = 12'sd2000;
  localparam logic [FAIL_W-1:0]          FAIL_MAX   = 4'd15;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TEMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT = 3'd6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] min_temp;
    logic signed [SAMPLE_W-1:0] limit_temp;
    logic [HYST_W-1:0]          hysteresis;
    logic [DUTY_W-1:0]          min_duty;
    logic [DUTY_W-1:0]          max_duty;
    logic [DUTY_W-1:0]          deadband;
    logic [FAIL_W-1:0]          error_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_temp:    12'sd320,
    limit_temp:  12'sd448,
    hysteresis:  9'd32,
    min_duty:    8'd50,
    max_duty:    8'd255,
    deadband:    8'd5,
    error_limit: 4'd5
  };

  typedef struct packed {
    logic                wr_en;
    logic [SAMPLE_W-1:0] wr_data;
    logic [SLOT_W-1:0]   rd_idx;
  } ring_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] rd_data;
    logic [CNT_W-1:0]    count;
  } ring_rsp_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [DUTY_W-1:0]          duty;
    logic                       duty_changed;
    logic                       sample_valid;
    logic signed [SAMPLE_W-1:0] smoothed;
    logic                       fail_safe;
    logic [FAIL_W-1:0]          failures;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_AVG_DIV,
    S_MUL_BASE,
    S_MUL_SLOPE,
    S_CURVE,
    S_CURVE_DIV,
    S_DECIDE,
    S_FAIL,
    S_DONE
  } state_t;

endpackage

>>> rtl/fdt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdt_in_if
// Sensor reading channel: one request carries a read-ok flag and a sample.
// ----------------------------------------------------------------------------
interface fdt_in_if;
  logic                                valid;
  logic                                ready;
  logic                                read_ok;
  logic signed [fdt_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output read_ok, output sample, input ready);
  modport sink (input valid, input read_ok, input sample, output ready);
endinterface

>>> rtl/fdt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdt_out_if
// Result channel: applied duty and status of one processed reading.
// ----------------------------------------------------------------------------
interface fdt_out_if;
  logic                                valid;
  logic                                ready;
  logic [fdt_pkg::DUTY_W-1:0]          duty;
  logic                                duty_changed;
  logic                                sample_valid;
  logic signed [fdt_pkg::SAMPLE_W-1:0] smoothed;
  logic                                fail_safe;
  logic [fdt_pkg::FAIL_W-1:0]          failures;

  modport source (output valid, output duty, output duty_changed, output sample_valid,
                  output smoothed, output fail_safe, output failures, input ready);
  modport sink (input valid, input duty, input duty_changed, input sample_valid,
                input smoothed, input fail_safe, input failures, output ready);
endinterface

>>> rtl/fdt_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdt_ring
// Averaging history: ring of valid readings with write slot and fill count.
// ----------------------------------------------------------------------------
module fdt_ring (
  input  logic               clk,
  input  logic               rst,
  input  fdt_pkg::ring_req_t req,
  output fdt_pkg::ring_rsp_t rsp
);

  logic [fdt_pkg::SAMPLE_W-1:0] history [fdt_pkg::AVG_DEPTH];
  logic [fdt_pkg::SLOT_W-1:0]   write_slot;
  logic                         ring_full;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      history[write_slot] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      ring_full  <= 1'b0;
    end else if (req.wr_en) begin
      if (write_slot == fdt_pkg::SLOT_W'(fdt_pkg::AVG_DEPTH - 1)) begin
        write_slot <= '0;
        ring_full  <= 1'b1;
      end else begin
        write_slot <= write_slot + 1'b1;
      end
    end
  end

  // entries filled so far, counted after the latest write
  assign rsp.count   = ring_full ? fdt_pkg::CNT_W'(fdt_pkg::AVG_DEPTH)
                                 : fdt_pkg::CNT_W'(write_slot);
  assign rsp.rd_data = history[req.rd_idx];

endmodule

>>> rtl/fdt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdt_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fdt_div (
  input  logic              clk,
  input  logic              rst,
  input  fdt_pkg::div_req_t req,
  output fdt_pkg::div_rsp_t rsp
);

  logic                             busy;
  logic                             done;
  logic [fdt_pkg::DIV_CNT_W-1:0]    cnt;
  logic [fdt_pkg::DIVIDEND_W-1:0]   quo;
  logic [fdt_pkg::DIVISOR_W-1:0]    rem;
  logic [fdt_pkg::DIVISOR_W-1:0]    divisor;
  logic [fdt_pkg::DIVISOR_W:0]      rem_sh;
  logic [fdt_pkg::DIVISOR_W:0]      rem_sub;
  logic                             fits;

  assign rem_sh  = {rem, quo[fdt_pkg::DIVIDEND_W-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == fdt_pkg::DIV_CNT_W'(fdt_pkg::DIVIDEND_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt     <= '0;
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      rem <= fits ? rem_sub[fdt_pkg::DIVISOR_W-1:0] : rem_sh[fdt_pkg::DIVISOR_W-1:0];
      quo <= {quo[fdt_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

>>> rtl/fdt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdt_ctrl
// Sequencer: ring sum, average, fan curve, deadband and failure handling.
// ----------------------------------------------------------------------------
module fdt_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  fdt_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_read_ok,
  input  logic signed [fdt_pkg::SAMPLE_W-1:0] in_sample,
  output fdt_pkg::ring_req_t                  ring_req,
  input  fdt_pkg::ring_rsp_t                  ring_rsp,
  output fdt_pkg::div_req_t                   div_req,
  input  fdt_pkg::div_rsp_t                   div_rsp,
  output logic                                res_valid,
  input  logic                                res_take,
  output fdt_pkg::result_t                    res
);

  fdt_pkg::state_t state;
  fdt_pkg::state_t state_next;

  logic [fdt_pkg::SLOT_W-1:0]          idx;
  logic signed [fdt_pkg::SUM_W-1:0]    sum;
  logic signed [fdt_pkg::SUM_W-1:0]    sum_new;
  logic [fdt_pkg::SUM_W-1:0]           sum_mag;
  logic                                sum_neg;
  logic                                last_entry;
  logic                                sample_ok;
  logic [fdt_pkg::SAMPLE_W-1:0]        q_avg;

  logic signed [fdt_pkg::SAMPLE_W-1:0] smoothed;
  logic signed [fdt_pkg::PROD_W-1:0]   acc;
  logic signed [fdt_pkg::PROD_W-1:0]   prod;
  logic signed [fdt_pkg::CALC_W-1:0]   t_x;
  logic signed [fdt_pkg::CALC_W-1:0]   lo_x;
  logic signed [fdt_pkg::CALC_W-1:0]   hi_x;
  logic signed [fdt_pkg::CALC_W-1:0]   top_x;
  logic signed [fdt_pkg::CALC_W-1:0]   span;
  logic signed [fdt_pkg::CALC_W-1:0]   t_lo;
  logic signed [fdt_pkg::DD_W-1:0]     duty_span;
  logic signed [fdt_pkg::CALC_W-1:0]   mul_a;
  logic signed [fdt_pkg::DD_W-1:0]     mul_b;
  logic                                curve_div;
  logic [fdt_pkg::DUTY_W-1:0]          curve_target;
  logic [fdt_pkg::DUTY_W-1:0]          div_target;

  logic [fdt_pkg::DUTY_W-1:0]          target;
  logic [fdt_pkg::DUTY_W-1:0]          applied_duty;
  logic                                fan_running;
  logic [fdt_pkg::FAIL_W-1:0]          fail_count;
  logic [fdt_pkg::FAIL_W-1:0]          fail_inc;
  logic                                fail_trip;
  logic signed [fdt_pkg::DUTY_W:0]     duty_diff;
  logic [fdt_pkg::DUTY_W:0]            duty_adiff;
  logic                                apply_new;

  logic                                changed;
  logic                                safe;
  logic                                sval;

  // ---- reading and ring sum
  assign sample_ok  = in_read_ok && (in_sample > fdt_pkg::LOW_BOUND)
                      && (in_sample < fdt_pkg::HIGH_BOUND);
  assign sum_new    = sum + fdt_pkg::SUM_W'(signed'(ring_rsp.rd_data));
  assign sum_mag    = sum_new[fdt_pkg::SUM_W-1] ? -sum_new : sum_new;
  assign last_entry = fdt_pkg::CNT_W'(idx) == (ring_rsp.count - 1'b1);
  assign q_avg      = div_rsp.quotient[fdt_pkg::SAMPLE_W-1:0];

  // ---- curve terms
  assign t_x       = fdt_pkg::CALC_W'(smoothed);
  assign lo_x      = fdt_pkg::CALC_W'(cfg.min_temp);
  assign hi_x      = fdt_pkg::CALC_W'(cfg.limit_temp);
  assign top_x     = hi_x + signed'(fdt_pkg::CALC_W'(cfg.hysteresis));
  assign span      = hi_x - lo_x;
  assign t_lo      = t_x - lo_x;
  assign duty_span = signed'({2'b00, cfg.max_duty}) - signed'({2'b00, cfg.min_duty});

  // one multiplier: min_duty * span first, then (t - lo) * (max - min)
  assign mul_a = (state == fdt_pkg::S_MUL_BASE) ? span : t_lo;
  assign mul_b = (state == fdt_pkg::S_MUL_BASE) ? signed'({2'b00, cfg.min_duty}) : duty_span;
  assign prod  = fdt_pkg::PROD_W'(mul_a) * fdt_pkg::PROD_W'(mul_b);

  always_comb begin
    curve_div    = 1'b0;
    curve_target = '0;
    priority if (t_x < lo_x) begin
      curve_target = '0;
    end else if (t_x >= top_x || (t_x > hi_x && fan_running)) begin
      curve_target = cfg.max_duty;
    end else if (span[fdt_pkg::CALC_W-1] || span == '0) begin
      curve_target = cfg.max_duty;
    end else if (acc[fdt_pkg::PROD_W-1]) begin
      // negative numerator truncates to zero or below
      curve_target = '0;
    end else begin
      curve_div = 1'b1;
    end
  end

  assign div_target = (div_rsp.quotient > fdt_pkg::DIVIDEND_W'(cfg.max_duty))
                      ? cfg.max_duty : div_rsp.quotient[fdt_pkg::DUTY_W-1:0];

  // ---- deadband and failure counting
  assign duty_diff  = signed'({1'b0, target}) - signed'({1'b0, applied_duty});
  assign duty_adiff = duty_diff[fdt_pkg::DUTY_W] ? -duty_diff : duty_diff;
  assign apply_new  = (duty_adiff > {1'b0, cfg.deadband})
                      || (target == '0 && applied_duty != '0)
                      || (target != '0 && applied_duty == '0);
  assign fail_inc   = (fail_count == fdt_pkg::FAIL_MAX) ? fail_count : fail_count + 1'b1;
  assign fail_trip  = fail_inc >= cfg.error_limit;

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    res_valid        = 1'b0;
    ring_req.wr_en   = 1'b0;
    ring_req.wr_data = in_sample;
    ring_req.rd_idx  = idx;
    div_req.start    = 1'b0;
    div_req.dividend = fdt_pkg::DIVIDEND_W'(sum_mag);
    div_req.divisor  = fdt_pkg::DIVISOR_W'(ring_rsp.count);
    unique case (state)
      fdt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ring_req.wr_en = sample_ok;
          state_next     = sample_ok ? fdt_pkg::S_SUM : fdt_pkg::S_FAIL;
        end
      end
      fdt_pkg::S_SUM: begin
        if (last_entry) begin
          div_req.start = 1'b1;
          state_next    = fdt_pkg::S_AVG_DIV;
        end
      end
      fdt_pkg::S_AVG_DIV: begin
        if (div_rsp.done) begin
          state_next = fdt_pkg::S_MUL_BASE;
        end
      end
      fdt_pkg::S_MUL_BASE: begin
        state_next = fdt_pkg::S_MUL_SLOPE;
      end
      fdt_pkg::S_MUL_SLOPE: begin
        state_next = fdt_pkg::S_CURVE;
      end
      fdt_pkg::S_CURVE: begin
        div_req.dividend = fdt_pkg::DIVIDEND_W'(acc);
        div_req.divisor  = fdt_pkg::DIVISOR_W'(span);
        if (curve_div) begin
          div_req.start = 1'b1;
          state_next    = fdt_pkg::S_CURVE_DIV;
        end else begin
          state_next = fdt_pkg::S_DECIDE;
        end
      end
      fdt_pkg::S_CURVE_DIV: begin
        if (div_rsp.done) begin
          state_next = fdt_pkg::S_DECIDE;
        end
      end
      fdt_pkg::S_DECIDE: begin
        state_next = fdt_pkg::S_DONE;
      end
      fdt_pkg::S_FAIL: begin
        state_next = fdt_pkg::S_DONE;
      end
      fdt_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = fdt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fdt_pkg::S_IDLE;
      end
    endcase
  end

  // ---- persistent fan state
  always_ff @(posedge clk) begin
    if (rst) begin
      applied_duty <= '0;
      fan_running  <= 1'b0;
      fail_count   <= '0;
    end else if (state == fdt_pkg::S_FAIL) begin
      fail_count <= fail_inc;
      if (fail_trip) begin
        applied_duty <= cfg.max_duty;
        fan_running  <= 1'b1;
      end
    end else if (state == fdt_pkg::S_DECIDE) begin
      fail_count <= '0;
      if (apply_new) begin
        applied_duty <= target;
        fan_running  <= target != '0;
      end
    end
  end

  // ---- working registers
  always_ff @(posedge clk) begin
    unique case (state)
      fdt_pkg::S_IDLE: begin
        idx <= '0;
        sum <= '0;
      end
      fdt_pkg::S_SUM: begin
        idx     <= idx + 1'b1;
        sum     <= sum_new;
        sum_neg <= sum_new[fdt_pkg::SUM_W-1];
      end
      fdt_pkg::S_AVG_DIV: begin
        if (div_rsp.done) begin
          smoothed <= sum_neg ? -q_avg : q_avg;
        end
      end
      fdt_pkg::S_MUL_BASE: begin
        acc <= prod;
      end
      fdt_pkg::S_MUL_SLOPE: begin
        acc <= acc + prod;
      end
      fdt_pkg::S_CURVE: begin
        target <= curve_target;
      end
      fdt_pkg::S_CURVE_DIV: begin
        if (div_rsp.done) begin
          target <= div_target;
        end
      end
      fdt_pkg::S_DECIDE: begin
        changed <= apply_new;
        safe    <= 1'b0;
        sval    <= 1'b1;
      end
      fdt_pkg::S_FAIL: begin
        smoothed <= '0;
        changed  <= fail_trip;
        safe     <= fail_trip;
        sval     <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign res.duty         = applied_duty;
  assign res.duty_changed = changed;
  assign res.sample_valid = sval;
  assign res.smoothed     = smoothed;
  assign res.fail_safe    = safe;
  assign res.failures     = fail_count;

endmodule

>>> rtl/fan_duty_from_temperature_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_duty_from_temperature_top
// Fan duty from smoothed temperature with hysteresis, deadband and fail-safe.
// ----------------------------------------------------------------------------
// in_ch takes one sensor request (read_ok, sample) at a time; out_ch returns
// exactly one result per request through an output register, so a result may
// wait on the receiver while the next request is already taken.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data. The
// user must write it only while the block is idle; the block does not
// enforce this. A write to an index beyond the register list is ignored.
// A good reading with n filled ring entries (1 to 5) is summed, divided by n
// in the shared restoring divider (24 quotient bits at one bit per cycle),
// passes the two curve multiply steps and, only where the curve needs it, is
// divided again for the slope; a failed reading goes straight to a result.
// A request is taken only between items, so one item is in work at a time;
// the next request can be taken the cycle after a result leaves the
// sequencer. If the receiver stalls, the result holds in the output register
// and a second finished result waits in the sequencer until it drains.
// Reset (rst, synchronous) restores the register defaults, empties the ring
// and clears applied duty, fan state and the failure count.
// ----------------------------------------------------------------------------
module fan_duty_from_temperature_top (
  input  logic                              clk,
  input  logic                              rst,
  fdt_in_if.sink                            in_ch,
  fdt_out_if.source                         out_ch,
  input  logic                              cfg_wr_en,
  input  logic [fdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fdt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  fdt_pkg::cfg_t      cfg;
  fdt_pkg::ring_req_t ring_req;
  fdt_pkg::ring_rsp_t ring_rsp;
  fdt_pkg::div_req_t  div_req;
  fdt_pkg::div_rsp_t  div_rsp;
  fdt_pkg::result_t   res;
  logic               res_valid;
  logic               res_take;

  // ---- register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= fdt_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fdt_pkg::CFG_MIN_TEMP:    cfg.min_temp    <= signed'(cfg_data[fdt_pkg::SAMPLE_W-1:0]);
        fdt_pkg::CFG_LIMIT_TEMP:  cfg.limit_temp  <= signed'(cfg_data[fdt_pkg::SAMPLE_W-1:0]);
        fdt_pkg::CFG_HYSTERESIS:  cfg.hysteresis  <= cfg_data[fdt_pkg::HYST_W-1:0];
        fdt_pkg::CFG_MIN_DUTY:    cfg.min_duty    <= cfg_data[fdt_pkg::DUTY_W-1:0];
        fdt_pkg::CFG_MAX_DUTY:    cfg.max_duty    <= cfg_data[fdt_pkg::DUTY_W-1:0];
        fdt_pkg::CFG_DEADBAND:    cfg.deadband    <= cfg_data[fdt_pkg::DUTY_W-1:0];
        fdt_pkg::CFG_ERROR_LIMIT: cfg.error_limit <= cfg_data[fdt_pkg::FAIL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fdt_ring u_ring (
    .clk (clk),
    .rst (rst),
    .req (ring_req),
    .rsp (ring_rsp)
  );

  fdt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fdt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_read_ok (in_ch.read_ok),
    .in_sample  (in_ch.sample),
    .ring_req   (ring_req),
    .ring_rsp   (ring_rsp),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // ---- output register
  assign res_take = res_valid && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (res_take) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_ch.duty         <= res.duty;
      out_ch.duty_changed <= res.duty_changed;
      out_ch.sample_valid <= res.sample_valid;
      out_ch.smoothed     <= res.smoothed;
      out_ch.fail_safe    <= res.fail_safe;
      out_ch.failures     <= res.failures;
    end
  end

endmodule
